FILE: design/mwed_pkg.sv
// Shared types and constants for the multibit watermark embed/detect core.
// Depends on nothing; every module of the core imports it.
package mwed_pkg;

   localparam int NUM_PATTERNS      = 8;
   localparam int PATTERN_FRAC_BITS = 8;
   localparam int ACC_WIDTH         = 40;
   localparam int GAIN_FRAC_BITS    = 8;

   localparam int PIXEL_WIDTH   = 8;
   localparam int PATTERN_WIDTH = 12;
   localparam int GAIN_WIDTH    = 10;
   localparam int MSG_WIDTH     = 8;

   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET  = GAIN_WIDTH'(724);
   localparam logic [PIXEL_WIDTH-1:0] PIXEL_MAX  = PIXEL_WIDTH'(255);

   // Arithmetic widths
   localparam int TERM_WIDTH  = PATTERN_WIDTH + 1;
   localparam int SUM_WIDTH   = TERM_WIDTH + $clog2(NUM_PATTERNS + 1);
   localparam int PROD_WIDTH  = PIXEL_WIDTH + PATTERN_WIDTH;
   localparam int MULT_WIDTH  = GAIN_WIDTH + SUM_WIDTH + 1;
   localparam int ALIGN_SHIFT = PATTERN_FRAC_BITS + GAIN_FRAC_BITS;
   localparam int ALIGN_WIDTH = PIXEL_WIDTH + ALIGN_SHIFT;
   localparam int TOTAL_WIDTH = ((ALIGN_WIDTH > MULT_WIDTH) ? ALIGN_WIDTH : MULT_WIDTH) + 1;

   // Configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic {
      REG_GAIN    = 1'b0,
      REG_MESSAGE = 1'b1
   } reg_index_type;

   typedef logic signed [PATTERN_WIDTH-1:0] sample_type;
   typedef logic signed [TERM_WIDTH-1:0]    term_type;

   typedef struct packed {
      logic                   op;
      logic [PIXEL_WIDTH-1:0] pixel;
      sample_type             pattern_0;
      sample_type             pattern_1;
      sample_type             pattern_2;
      sample_type             pattern_3;
      sample_type             pattern_4;
      sample_type             pattern_5;
      sample_type             pattern_6;
      sample_type             pattern_7;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_out;
      logic [MSG_WIDTH-1:0]   detected_message;
      logic                   is_detect;
   } rsp_type;

   // Pipeline control that travels alongside each item
   typedef struct packed {
      logic valid;
      logic op;
      logic last;
   } ctl_type;

   localparam logic OP_EMBED  = 1'b0;
   localparam logic OP_DETECT = 1'b1;

endpackage

FILE: design/mwed_lane.sv
// One pattern lane: signed embed term and correlation accumulator.
// Depends on mwed_pkg.
module mwed_lane
   import mwed_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [PIXEL_WIDTH-1:0] pixel,
   input  sample_type             sample,
   input  logic                   msg_bit,
   input  ctl_type                ctl1,
   output term_type               term,
   output logic                   decision
);

   logic signed [PIXEL_WIDTH+PATTERN_WIDTH:0] prod_full;
   term_type                        term_in, term_ff;
   logic signed [PROD_WIDTH-1:0]    prod_in, prod_ff;
   logic signed [ACC_WIDTH-1:0]     acc_sum, acc_in, acc_ff;
   logic                            decision_in, decision_ff;

   always_comb begin
      term_in   = msg_bit ? TERM_WIDTH'(sample) : -TERM_WIDTH'(sample);
      prod_full = $signed({1'b0, pixel}) * sample;
      prod_in   = $signed(prod_full[PROD_WIDTH-1:0]);
      acc_sum   = acc_ff + ACC_WIDTH'(prod_ff);
      // strictly positive correlation decodes a one
      decision_in = (acc_sum != '0) && !acc_sum[ACC_WIDTH-1];
      acc_in    = acc_ff;
      if (ctl1.valid && (ctl1.op == OP_DETECT)) begin
         acc_in = ctl1.last ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      term_ff     <= term_in;
      prod_ff     <= prod_in;
      decision_ff <= decision_in;
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign term     = term_ff;
   assign decision = decision_ff;

endmodule

FILE: design/mwed_merge.sv
// Merge stage: sums lane terms, scales by gain, clamps the pixel; packs lane decisions.
// Depends on mwed_pkg.
module mwed_merge
   import mwed_pkg::*;
(
   input  logic                   clock,
   input  term_type               terms [NUM_PATTERNS],
   input  logic [NUM_PATTERNS-1:0] decisions,
   input  logic [PIXEL_WIDTH-1:0] pixel1,
   input  logic [GAIN_WIDTH-1:0]  gain,
   output logic [PIXEL_WIDTH-1:0] pixel_out,
   output logic [MSG_WIDTH-1:0]   message
);

   localparam int QWIDTH = TOTAL_WIDTH - ALIGN_SHIFT;

   logic signed [SUM_WIDTH-1:0]   sum_in, sum_ff;
   logic signed [MULT_WIDTH-1:0]  mult_in, mult_ff;
   logic [PIXEL_WIDTH-1:0]        pixel2_ff, pixel3_ff;
   logic [MSG_WIDTH-1:0]          message_in, message_ff;
   logic [ALIGN_WIDTH-1:0]        aligned;
   logic signed [TOTAL_WIDTH-1:0] total;
   logic [QWIDTH-1:0]             quot;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         sum_in = sum_in + SUM_WIDTH'(terms[k]);
      end
      mult_in = $signed({1'b0, gain}) * sum_ff;
      message_in = '0;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         message_in[NUM_PATTERNS-1-k] = decisions[k];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      pixel2_ff  <= pixel1;
      mult_ff    <= mult_in;
      pixel3_ff  <= pixel2_ff;
      message_ff <= message_in;
   end

   // Truncate toward zero: negative totals floor to 0, large ones clamp high
   always_comb begin
      aligned = {pixel3_ff, {ALIGN_SHIFT{1'b0}}};
      total   = TOTAL_WIDTH'($signed({1'b0, aligned})) + TOTAL_WIDTH'(mult_ff);
      quot    = total[TOTAL_WIDTH-1:ALIGN_SHIFT];
      if (total[TOTAL_WIDTH-1]) begin
         pixel_out = '0;
      end else if (|quot[QWIDTH-1:PIXEL_WIDTH]) begin
         pixel_out = PIXEL_MAX;
      end else begin
         pixel_out = quot[PIXEL_WIDTH-1:0];
      end
   end

   assign message = message_ff;

endmodule

FILE: design/multibit_watermark_embed_detect_core.sv
// Multibit spread-spectrum watermark core: embeds a message into pixels, or detects it.
// An item's result is pushed to the result queue from ctl3, after ctl1 and ctl2.
// Throughput: one item per cycle unless stalled; eight pattern lanes work in parallel.
// req_stall rises only while the eight-entry result queue holds five or more items.
// Sync active-high reset clears accumulators, queue, control and message; gain to 724.
// Depends on mwed_pkg, mwed_lane, mwed_merge.
module multibit_watermark_embed_detect_core
   import mwed_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // input item channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   // result item channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   // configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int PIPE_STAGES = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
   localparam int CNT_WIDTH   = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] STALL_LEVEL = CNT_WIDTH'(FIFO_DEPTH - PIPE_STAGES);

   //------------------------------------------------------------------
   // Configuration registers
   //------------------------------------------------------------------
   logic [GAIN_WIDTH-1:0] gain_ff, gain_in;
   logic [MSG_WIDTH-1:0]  message_ff, message_in;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      gain_in    = gain_ff;
      message_in = message_ff;
      csr_prdata = '0;
      unique case (csr_index)
         REG_GAIN: begin
            csr_prdata = CSR_DATA_WIDTH'(gain_ff);
            if (csr_write) begin
               gain_in = csr_pwdata[GAIN_WIDTH-1:0];
            end
         end
         REG_MESSAGE: begin
            csr_prdata = CSR_DATA_WIDTH'(message_ff);
            if (csr_write) begin
               message_in = csr_pwdata[MSG_WIDTH-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= GAIN_RESET;
         message_ff <= '0;
      end else begin
         gain_ff    <= gain_in;
         message_ff <= message_in;
      end
   end

   //------------------------------------------------------------------
   // Input acceptance and control pipeline
   //------------------------------------------------------------------
   logic                   req_accept;
   ctl_type                ctl0, ctl1_ff, ctl2_ff, ctl3_ff;
   logic [PIXEL_WIDTH-1:0] pixel1_ff;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   // Stall on queue level alone; at most three items ahead still need a slot
   assign req_stall  = (count_ff >= STALL_LEVEL);
   assign req_accept = req_valid && !req_stall;

   assign ctl0.valid = req_accept;
   assign ctl0.op    = req_data.op;
   assign ctl0.last  = req_data.last;

   always_ff @(posedge clock) begin
      pixel1_ff <= req_data.pixel;
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= ctl0;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   //------------------------------------------------------------------
   // Pattern lanes: one per reference pattern
   //------------------------------------------------------------------
   sample_type              samples   [8];
   term_type                terms     [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0] decisions;

   assign samples[0] = req_data.pattern_0;
   assign samples[1] = req_data.pattern_1;
   assign samples[2] = req_data.pattern_2;
   assign samples[3] = req_data.pattern_3;
   assign samples[4] = req_data.pattern_4;
   assign samples[5] = req_data.pattern_5;
   assign samples[6] = req_data.pattern_6;
   assign samples[7] = req_data.pattern_7;

   for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_lane
      mwed_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .pixel    (req_data.pixel),
         .sample   (samples[k]),
         .msg_bit  (message_ff[NUM_PATTERNS-1-k]),
         .ctl1     (ctl1_ff),
         .term     (terms[k]),
         .decision (decisions[k])
      );
   end

   //------------------------------------------------------------------
   // Merge: embed arithmetic and message assembly
   //------------------------------------------------------------------
   logic [PIXEL_WIDTH-1:0] merged_pixel;
   logic [MSG_WIDTH-1:0]   merged_message;

   mwed_merge u_merge (
      .clock     (clock),
      .terms     (terms),
      .decisions (decisions),
      .pixel1    (pixel1_ff),
      .gain      (gain_ff),
      .pixel_out (merged_pixel),
      .message   (merged_message)
   );

   //------------------------------------------------------------------
   // Result queue: decouples the pipeline from result backpressure
   //------------------------------------------------------------------
   rsp_type                fifo_mem_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic                   push, pop;
   rsp_type                push_data;

   // Embed items always produce a result; detect items only on last
   assign push = ctl3_ff.valid && ((ctl3_ff.op == OP_EMBED) || ctl3_ff.last);
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      push_data.is_detect        = ctl3_ff.op;
      push_data.pixel_out        = (ctl3_ff.op == OP_EMBED) ? merged_pixel : '0;
      push_data.detected_message = (ctl3_ff.op == OP_DETECT) ? merged_message : '0;
      wr_ptr_in = push ? wr_ptr_ff + PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_mem_ff[rd_ptr_ff];

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(FIFO_DEPTH))
      else $error("result queue level above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_WIDTH'(FIFO_DEPTH)) || pop)
      else $error("result pushed into a full queue");

   a_embed_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.op == OP_EMBED)) |-> ##3 push)
      else $error("embed item produced no result");

   a_detect_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.op == OP_DETECT) && !req_data.last) |-> ##3 !push)
      else $error("detect item without last produced a result");

endmodule
